// File: sv/pts_pkg.sv
// Shared constants, codes and helpers for the priority thread scheduler.
`default_nettype none
package pts_pkg;
  localparam int THREAD_SLOTS = 16;
  localparam int EVENT_SLOTS  = 8;
  localparam int SW  = $clog2(THREAD_SLOTS);
  localparam int CW  = $clog2(THREAD_SLOTS + 1);
  localparam int EW  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int ECW = $clog2(EVENT_SLOTS + 1);
  localparam int IN_W  = 128;
  localparam int OUT_W = 96;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_SCHEDULE  = 3'd1;
  localparam logic [2:0] CMD_ADD       = 3'd2;
  localparam logic [2:0] CMD_KILL      = 3'd3;
  localparam logic [2:0] CMD_KILL_SELF = 3'd4;
  localparam logic [2:0] CMD_SLEEP     = 3'd5;
  localparam logic [2:0] CMD_PERIODIC  = 3'd6;
  localparam logic [2:0] CMD_BLOCK     = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NO_KILL = 2'd2;
  localparam logic [1:0] ST_NO_THR  = 2'd3;

  typedef logic [SW-1:0] slot_t;

  function automatic slot_t safe_slot(input slot_t s);
    return ({1'b0, s} < (SW+1)'(THREAD_SLOTS)) ? s : '0;
  endfunction
endpackage
`default_nettype wire

// File: sv/pts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/priority_thread_scheduler.sv
// Priority thread scheduler top level: command decode, table walks and result register.
// One request per command; the result comes back on the master side. Thread
// priority, wake time, identifier and ring links live in small RAMs, the
// periodic events in a further RAM; alive, asleep and blocked flags are
// flip-flops cleared by reset. Schedule follows one ring link per cycle
// through the link RAM read port; kill by id scans the identifiers, one
// slot a cycle; tick scans the wake times, then does one event
// read-modify-write a cycle. A new request is taken while the previous
// result still waits on the master side.
`default_nettype none
module priority_thread_scheduler (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // command[2:0] priority_req[10:3] thread_id[26:11] slot[30:27] block_flag[31]
  // duration[63:32] period[95:64] first_time[127:96]
  input  wire logic [pts_pkg::IN_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // status[1:0] current_slot[5:2] current_id[21:6] thread_count[26:22]
  // new_slot[30:27] new_id[46:31] fired_mask[54:47] preempt[55]
  // killed_was_blocked[56] time_now[88:57], zero above
  output logic [pts_pkg::OUT_W-1:0]     m_tdata
);
  import pts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_TW, S_TE, S_SCH0, S_SCH1, S_WALK, S_ADD1, S_ADD2,
    S_KS, S_UNL, S_FIN, S_RES
  } state_t;

  state_t state;

  // latched request
  logic [2:0]  cmd;
  logic [7:0]  prio_req;
  logic [15:0] tid;
  logic [3:0]  slot_in;
  logic        bflag;
  logic [31:0] dur, per, first;

  // scheduler state
  logic [THREAD_SLOTS-1:0] alive, asleep, blocked;
  slot_t       running;
  logic [CW-1:0]  live;
  logic [15:0] id_counter;
  logic [31:0] tick_count;
  logic [ECW-1:0] event_count;

  // working registers
  slot_t       chk, tgt, best;
  logic [7:0]  best_prio;
  logic [CW-1:0] cnt;
  logic [EW-1:0] ev;

  // result fields
  logic [1:0]  status;
  slot_t       new_slot;
  logic [15:0] new_id;
  logic [7:0]  mask;
  logic        preempt, kwb;

  // RAM ports
  slot_t       t_raddr;
  logic        prio_we, wake_we, ident_we, next_we, prev_we, ev_we;
  slot_t       prio_wa, wake_wa, ident_wa, next_wa, prev_wa;
  logic [7:0]  prio_wd, prio_rd;
  logic [31:0] wake_wd, wake_rd;
  logic [15:0] ident_wd, ident_rd;
  slot_t       next_wd, next_rd, prev_wd, prev_rd;
  logic [EW-1:0] ev_wa, ev_ra;
  logic [63:0] ev_wd, ev_rd;

  pts_ram #(.WIDTH(8), .DEPTH(THREAD_SLOTS)) u_prio (
    .clk(clk), .we(prio_we), .waddr(prio_wa), .wdata(prio_wd),
    .raddr(t_raddr), .rdata(prio_rd));
  pts_ram #(.WIDTH(32), .DEPTH(THREAD_SLOTS)) u_wake (
    .clk(clk), .we(wake_we), .waddr(wake_wa), .wdata(wake_wd),
    .raddr(t_raddr), .rdata(wake_rd));
  pts_ram #(.WIDTH(16), .DEPTH(THREAD_SLOTS)) u_ident (
    .clk(clk), .we(ident_we), .waddr(ident_wa), .wdata(ident_wd),
    .raddr(t_raddr), .rdata(ident_rd));
  pts_ram #(.WIDTH(SW), .DEPTH(THREAD_SLOTS)) u_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(t_raddr), .rdata(next_rd));
  pts_ram #(.WIDTH(SW), .DEPTH(THREAD_SLOTS)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(t_raddr), .rdata(prev_rd));
  // event entry: period in the upper word, next due time in the lower
  pts_ram #(.WIDTH(64), .DEPTH(EVENT_SLOTS)) u_event (
    .clk(clk), .we(ev_we), .waddr(ev_wa), .wdata(ev_wd),
    .raddr(ev_ra), .rdata(ev_rd));

  // slot for a new thread: id_counter when it names a free slot, else lowest free slot
  slot_t free_idx, add_idx;
  always_comb begin
    free_idx = '0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (!alive[i]) begin
        free_idx = SW'(i);
      end
    end
    if (id_counter < 16'(THREAD_SLOTS) && !alive[id_counter[SW-1:0]]) begin
      add_idx = id_counter[SW-1:0];
    end else begin
      add_idx = free_idx;
    end
  end

  // ring walk: slot under test is chk, its entry is on the RAM outputs
  logic  walk_take;
  slot_t walk_best, link_n, link_p;
  logic  blk_ok;
  always_comb begin
    walk_take = alive[chk] && !blocked[chk] && !asleep[chk] && (prio_rd < best_prio);
    walk_best = walk_take ? chk : best;
    link_n    = safe_slot(next_rd);
    link_p    = safe_slot(prev_rd);
    blk_ok    = {28'd0, slot_in} < 32'(THREAD_SLOTS);
  end

  // RAM control
  always_comb begin
    t_raddr  = '0;
    ev_ra    = '0;
    prio_we  = 1'b0; prio_wa  = add_idx; prio_wd  = prio_req;
    ident_we = 1'b0; ident_wa = add_idx; ident_wd = id_counter;
    wake_we  = 1'b0; wake_wa  = add_idx; wake_wd  = 32'd0;
    next_we  = 1'b0; next_wa  = '0;      next_wd  = '0;
    prev_we  = 1'b0; prev_wa  = '0;      prev_wd  = '0;
    ev_we    = 1'b0; ev_wa    = ev;
    ev_wd    = {ev_rd[63:32], ev_rd[31:0] + ev_rd[63:32]};
    unique case (state)
      S_CMD: begin
        unique case (cmd)
          CMD_TICK: begin
            t_raddr = '0;
          end
          CMD_SCHEDULE: begin
            t_raddr = '0;
          end
          CMD_ADD: begin
            t_raddr = '0;
            if (live < CW'(THREAD_SLOTS)) begin
              prio_we  = 1'b1;
              ident_we = 1'b1;
              wake_we  = 1'b1;
              if (live == '0) begin
                next_we = 1'b1; next_wa = add_idx; next_wd = add_idx;
                prev_we = 1'b1; prev_wa = add_idx; prev_wd = add_idx;
              end
            end
          end
          CMD_KILL: begin
            t_raddr = slot_t'(1);
          end
          CMD_KILL_SELF: begin
            t_raddr = running;
          end
          CMD_SLEEP: begin
            wake_we = 1'b1;
            wake_wa = running;
            wake_wd = tick_count + dur;
          end
          CMD_PERIODIC: begin
            if (event_count < ECW'(EVENT_SLOTS)) begin
              ev_we = 1'b1;
              ev_wa = EW'(event_count);
              ev_wd = {per, first};
            end
          end
          CMD_BLOCK: begin
            t_raddr = '0;
          end
          default: begin
            t_raddr = '0;
          end
        endcase
      end
      S_TW: begin
        t_raddr = chk + slot_t'(1);
        ev_ra   = '0;
      end
      S_TE: begin
        ev_ra = ev + EW'(1);
        ev_we = (ev_rd[31:0] == tick_count);
      end
      S_SCH0: begin
        t_raddr = running;
      end
      S_SCH1: begin
        t_raddr = link_n;
      end
      S_WALK: begin
        t_raddr = link_n;
      end
      S_ADD1: begin
        prev_we = 1'b1; prev_wa = tgt;    prev_wd = link_p;
        next_we = 1'b1; next_wa = link_p; next_wd = tgt;
      end
      S_ADD2: begin
        prev_we = 1'b1; prev_wa = '0;  prev_wd = tgt;
        next_we = 1'b1; next_wa = tgt; next_wd = '0;
      end
      S_KS: begin
        if (alive[chk] && ident_rd == tid) begin
          t_raddr = chk;
        end else begin
          t_raddr = chk + slot_t'(1);
        end
      end
      S_UNL: begin
        // bridge the neighbors of the removed slot
        next_we = 1'b1; next_wa = link_p; next_wd = link_n;
        prev_we = 1'b1; prev_wa = link_n; prev_wd = link_p;
      end
      S_FIN: begin
        t_raddr = running;
      end
      default: begin
        t_raddr = running;
      end
    endcase
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      alive       <= '0;
      asleep      <= '0;
      blocked     <= '0;
      running     <= '0;
      live        <= '0;
      id_counter  <= '0;
      tick_count  <= '0;
      event_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // S_RES reloads the result register itself
      if (m_tvalid && m_tready && state != S_RES) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd      <= s_tdata[2:0];
            prio_req <= s_tdata[10:3];
            tid      <= s_tdata[26:11];
            slot_in  <= s_tdata[30:27];
            bflag    <= s_tdata[31];
            dur      <= s_tdata[63:32];
            per      <= s_tdata[95:64];
            first    <= s_tdata[127:96];
            status   <= ST_OK;
            new_slot <= '0;
            new_id   <= '0;
            mask     <= '0;
            preempt  <= 1'b0;
            kwb      <= 1'b0;
            state    <= S_CMD;
          end
        end
        S_CMD: begin
          state <= S_FIN;
          unique case (cmd)
            CMD_TICK: begin
              tick_count <= tick_count + 32'd1;
              preempt    <= 1'b1;
              chk        <= '0;
              state      <= S_TW;
            end
            CMD_SCHEDULE: begin
              if (live == '0) begin
                running <= '0;
              end else begin
                state <= S_SCH0;
              end
            end
            CMD_ADD: begin
              if (live >= CW'(THREAD_SLOTS)) begin
                status <= ST_FULL;
              end else begin
                alive[add_idx]   <= 1'b1;
                asleep[add_idx]  <= 1'b0;
                blocked[add_idx] <= 1'b0;
                id_counter       <= id_counter + 16'd1;
                new_slot         <= add_idx;
                new_id           <= id_counter;
                tgt              <= add_idx;
                if (live == '0) begin
                  live <= live + CW'(1);
                end else begin
                  state <= S_ADD1;
                end
              end
            end
            CMD_KILL: begin
              if (tid == 16'd0 || live <= CW'(2)) begin
                status <= ST_NO_KILL;
              end else begin
                chk   <= slot_t'(1);
                state <= S_KS;
              end
            end
            CMD_KILL_SELF: begin
              if (live <= CW'(2) || running == '0) begin
                status <= ST_NO_KILL;
              end else if (!alive[running]) begin
                status <= ST_NO_THR;
              end else begin
                tgt     <= running;
                preempt <= 1'b1;
                state   <= S_UNL;
              end
            end
            CMD_SLEEP: begin
              asleep[running] <= 1'b1;
              preempt         <= 1'b1;
            end
            CMD_PERIODIC: begin
              if (event_count >= ECW'(EVENT_SLOTS)) begin
                status <= ST_FULL;
              end else begin
                event_count <= event_count + ECW'(1);
              end
            end
            CMD_BLOCK: begin
              if (blk_ok) begin
                blocked[SW'(slot_in)] <= bflag;
              end
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        // wake scan: wake time of slot chk on the RAM output
        S_TW: begin
          if (asleep[chk] && wake_rd == tick_count) begin
            asleep[chk] <= 1'b0;
          end
          chk <= chk + slot_t'(1);
          if (chk == SW'(THREAD_SLOTS - 1)) begin
            ev <= '0;
            state <= (event_count == '0) ? S_FIN : S_TE;
          end
        end
        // event scan: entry ev on the RAM output, due time advanced in place
        S_TE: begin
          if (ev_rd[31:0] == tick_count) begin
            mask <= mask | (8'd1 << ev);
          end
          ev <= ev + EW'(1);
          if ((ECW'(ev) + ECW'(1)) == event_count) begin
            state <= S_FIN;
          end
        end
        S_SCH0: begin
          best      <= '0;
          best_prio <= prio_rd;
          state     <= S_SCH1;
        end
        S_SCH1: begin
          chk   <= link_n;
          cnt   <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          best <= walk_best;
          if (walk_take) begin
            best_prio <= prio_rd;
          end
          chk <= link_n;
          cnt <= cnt + CW'(1);
          if ((cnt + CW'(1)) == live) begin
            running <= walk_best;
            state   <= S_FIN;
          end
        end
        S_ADD1: begin
          state <= S_ADD2;
        end
        S_ADD2: begin
          live  <= live + CW'(1);
          state <= S_FIN;
        end
        // identifier search from slot 1, identifier of chk on the RAM output
        S_KS: begin
          if (alive[chk] && ident_rd == tid) begin
            tgt   <= chk;
            kwb   <= blocked[chk];
            state <= S_UNL;
          end else if (chk == SW'(THREAD_SLOTS - 1)) begin
            status <= ST_NO_THR;
            state  <= S_FIN;
          end else begin
            chk <= chk + slot_t'(1);
          end
        end
        S_UNL: begin
          alive[tgt] <= 1'b0;
          live       <= live - CW'(1);
          state      <= S_FIN;
        end
        S_FIN: begin
          state <= S_RES;
        end
        S_RES: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, tick_count, kwb, preempt, mask, new_id,
                         4'(new_slot), 5'(live),
                         (alive[running] ? ident_rd : 16'd0),
                         4'(running), status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// File: verif/tb_priority_thread_scheduler.sv
// Self-checking testbench for the priority thread scheduler.
`timescale 1ns / 1ps
module tb_priority_thread_scheduler;
  import pts_pkg::*;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_W-1:0]    m_tdata;

  typedef struct {
    logic [2:0]  command;
    logic [7:0]  priority_req;
    logic [15:0] thread_id;
    logic [3:0]  slot;
    logic        block_flag;
    logic [31:0] duration;
    logic [31:0] period;
    logic [31:0] first_time;
  } sched_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  current_slot;
    logic [15:0] current_id;
    logic [4:0]  thread_count;
    logic [3:0]  new_slot;
    logic [15:0] new_id;
    logic [7:0]  fired_mask;
    logic        preempt;
    logic        killed_was_blocked;
    logic [31:0] time_now;
  } sched_resp_t;

  priority_thread_scheduler i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Mirror of the scheduler's tables
  logic        alive   [THREAD_SLOTS];
  logic        asleep  [THREAD_SLOTS];
  logic        blocked [THREAD_SLOTS];
  logic [7:0]  prio_tab  [THREAD_SLOTS];
  logic [31:0] wake_tab  [THREAD_SLOTS];
  logic [15:0] ident_tab [THREAD_SLOTS];
  logic [3:0]  nxt [THREAD_SLOTS];
  logic [3:0]  prv [THREAD_SLOTS];
  logic [3:0]  run_slot;
  int          n_live;
  logic [15:0] next_id;
  logic [31:0] now_ticks;
  logic [31:0] ev_period [EVENT_SLOTS];
  logic [31:0] ev_due    [EVENT_SLOTS];
  int          n_events;

  sched_resp_t expected_resp_q[$];
  int          idle_pct;
  int          stall_pct;
  int          errors;
  int          quiet_cycles;

  localparam int WATCHDOG_LIMIT = 20000;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Remove a slot from the ring; links of the dead slot stay as they were.
  function automatic void unlink(input logic [3:0] s);
    logic [3:0] p;
    logic [3:0] n;
    p = prv[s];
    n = nxt[s];
    nxt[p] = n;
    prv[n] = p;
    alive[s] = 1'b0;
    n_live--;
  endfunction

  // Advance the mirror by one request and return the response it must produce.
  function automatic sched_resp_t predict_sched(input sched_req_t r);
    sched_resp_t o;
    logic [3:0]  best;
    logic [3:0]  cur;
    int          idx;
    int          hit;
    o = '{default: '0};
    case (r.command)
      CMD_TICK: begin
        now_ticks++;
        for (int i = 0; i < THREAD_SLOTS; i++)
          if (asleep[i] && wake_tab[i] == now_ticks) asleep[i] = 1'b0;
        for (int e = 0; e < n_events; e++)
          if (ev_due[e] == now_ticks) begin
            o.fired_mask[e] = 1'b1;
            ev_due[e] += ev_period[e];
          end
        o.preempt = 1'b1;
      end
      CMD_SCHEDULE: begin
        best = '0;
        cur  = run_slot;
        for (int i = 0; i < n_live; i++) begin
          cur = nxt[cur];
          if (!blocked[cur] && alive[cur] && !asleep[cur] && prio_tab[cur] < prio_tab[best])
            best = cur;
        end
        run_slot = best;
      end
      CMD_ADD: begin
        if (n_live >= THREAD_SLOTS) begin
          o.status = ST_FULL;
        end else begin
          idx = THREAD_SLOTS;
          if (next_id < THREAD_SLOTS && !alive[next_id[3:0]]) idx = next_id;
          for (int i = 0; i < THREAD_SLOTS && idx == THREAD_SLOTS; i++)
            if (!alive[i]) idx = i;
          blocked[idx]   = 1'b0;
          asleep[idx]    = 1'b0;
          wake_tab[idx]  = '0;
          alive[idx]     = 1'b1;
          prio_tab[idx]  = r.priority_req;
          ident_tab[idx] = next_id;
          next_id++;
          if (n_live == 0) begin
            nxt[idx] = 4'(idx);
            prv[idx] = 4'(idx);
          end else begin
            cur = prv[0];
            nxt[idx] = '0;
            prv[idx] = cur;
            nxt[cur] = 4'(idx);
            prv[0]   = 4'(idx);
          end
          n_live++;
          o.new_slot = 4'(idx);
          o.new_id   = ident_tab[idx];
        end
      end
      CMD_KILL: begin
        if (r.thread_id == 0 || n_live <= 2) begin
          o.status = ST_NO_KILL;
        end else begin
          hit = THREAD_SLOTS;
          for (int i = 1; i < THREAD_SLOTS && hit == THREAD_SLOTS; i++)
            if (alive[i] && ident_tab[i] == r.thread_id) hit = i;
          if (hit == THREAD_SLOTS) begin
            o.status = ST_NO_THR;
          end else begin
            unlink(4'(hit));
            o.killed_was_blocked = blocked[hit];
          end
        end
      end
      CMD_KILL_SELF: begin
        if (n_live <= 2 || run_slot == 0) o.status = ST_NO_KILL;
        else if (!alive[run_slot]) o.status = ST_NO_THR;
        else begin
          unlink(run_slot);
          o.preempt = 1'b1;
        end
      end
      CMD_SLEEP: begin
        wake_tab[run_slot] = now_ticks + r.duration;
        asleep[run_slot]   = 1'b1;
        o.preempt = 1'b1;
      end
      CMD_PERIODIC: begin
        if (n_events >= EVENT_SLOTS) begin
          o.status = ST_FULL;
        end else begin
          ev_period[n_events] = r.period;
          ev_due[n_events]    = r.first_time;
          n_events++;
        end
      end
      default: blocked[r.slot] = r.block_flag;  // slot field cannot exceed the table
    endcase
    o.current_slot = run_slot;
    o.current_id   = alive[run_slot] ? ident_tab[run_slot] : '0;
    o.thread_count = 5'(n_live);
    o.time_now     = now_ticks;
    return o;
  endfunction

  // Present one request; predict at the edge where it is taken.
  task automatic send_sched_req(input sched_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.first_time, r.period, r.duration, r.block_flag, r.slot,
                 r.thread_id, r.priority_req, r.command};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_resp_q.push_back(predict_sched(r));
  endtask

  function automatic sched_req_t random_req();
    sched_req_t r;
    r.command      = 3'($urandom_range(7));
    r.priority_req = 8'($urandom);
    r.thread_id    = 16'($urandom);
    r.slot         = 4'($urandom);
    r.block_flag   = 1'($urandom);
    r.duration     = $urandom;
    r.period       = $urandom;
    r.first_time   = $urandom;
    return r;
  endfunction

  task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] a = 0,
                          input logic [31:0] b = 0);
    sched_req_t r;
    r = random_req();
    r.command = cmd;
    case (cmd)
      CMD_ADD:      r.priority_req = a[7:0];
      CMD_KILL:     r.thread_id    = a[15:0];
      CMD_SLEEP:    r.duration     = a;
      CMD_PERIODIC: begin r.first_time = a; r.period = b; end
      CMD_BLOCK:    begin r.slot = a[3:0]; r.block_flag = b[0]; end
      default: ;
    endcase
    send_sched_req(r);
  endtask

  task automatic test_directed();
    send_cmd(CMD_SCHEDULE);                 // empty ring picks idle slot
    send_cmd(CMD_KILL_SELF);                // refused on empty ring
    send_cmd(CMD_SLEEP, 32'd0);
    send_cmd(CMD_ADD, 8'd255);              // idle thread lands in slot 0
    send_cmd(CMD_ADD, 8'd0);
    send_cmd(CMD_ADD, 8'd0);                // tie: earlier in walk wins
    send_cmd(CMD_ADD, 8'd128);
    send_cmd(CMD_SCHEDULE);
    send_cmd(CMD_BLOCK, 1, 1);
    send_cmd(CMD_SCHEDULE);
    send_cmd(CMD_BLOCK, 15, 1);             // slot not alive
    send_cmd(CMD_KILL, 0);                  // id zero refused
    send_cmd(CMD_KILL, 1);                  // blocked victim
    send_cmd(CMD_KILL, 16'hFFFF);           // no such thread
    send_cmd(CMD_SCHEDULE);
    send_cmd(CMD_KILL_SELF);
    send_cmd(CMD_KILL_SELF);                // running slot already dead; refused as two threads remain
    send_cmd(CMD_SLEEP, 32'd2);
    send_cmd(CMD_TICK);
    send_cmd(CMD_TICK);                     // sleeper wakes
    send_cmd(CMD_SLEEP, 32'hFFFF_FFFF);     // wake time wraps
    send_cmd(CMD_PERIODIC, now_ticks + 1, 32'd0);
    send_cmd(CMD_PERIODIC, now_ticks + 2, 32'd3);
    send_cmd(CMD_PERIODIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (4) send_cmd(CMD_TICK);
    repeat (THREAD_SLOTS) send_cmd(CMD_ADD, $urandom);  // fills, then table full
  endtask

  // Mostly meaningful commands with live ids and near-term times, some noise.
  task automatic test_random(input int count, input int idle, input int stall);
    sched_req_t r;
    int         k;
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) begin
      r = random_req();
      k = $urandom_range(99);
      if (k < 25) r.command = CMD_TICK;
      else if (k < 38) r.command = CMD_SCHEDULE;
      else if (k < 52) r.command = CMD_ADD;
      else if (k < 66) begin
        r.command = CMD_KILL;
        if ($urandom_range(3) != 0) r.thread_id = ident_tab[$urandom_range(THREAD_SLOTS - 1)];
      end else if (k < 71) r.command = CMD_KILL_SELF;
      else if (k < 79) begin
        r.command  = CMD_SLEEP;
        r.duration = $urandom_range(6);
      end else if (k < 82) begin
        r.command    = CMD_PERIODIC;
        r.first_time = now_ticks + $urandom_range(1, 5);
        r.period     = $urandom_range(4);
      end else if (k < 94) r.command = CMD_BLOCK;
      send_sched_req(r);
    end
  endtask

  // Response checker
  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    sched_resp_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_resp_q.size() == 0) begin
        $error("response with no request outstanding: %h", m_tdata);
        errors++;
      end else begin
        e = expected_resp_q.pop_front();
        check_field("status",             32'(e.status),             32'(m_tdata[1:0]));
        check_field("current_slot",       32'(e.current_slot),       32'(m_tdata[5:2]));
        check_field("current_id",         32'(e.current_id),         32'(m_tdata[21:6]));
        check_field("thread_count",       32'(e.thread_count),       32'(m_tdata[26:22]));
        check_field("new_slot",           32'(e.new_slot),           32'(m_tdata[30:27]));
        check_field("new_id",             32'(e.new_id),             32'(m_tdata[46:31]));
        check_field("fired_mask",         32'(e.fired_mask),         32'(m_tdata[54:47]));
        check_field("preempt",            32'(e.preempt),            32'(m_tdata[55]));
        check_field("killed_was_blocked", 32'(e.killed_was_blocked), 32'(m_tdata[56]));
        check_field("time_now",           e.time_now,                m_tdata[88:57]);
        check_field("upper bits",         32'd0,                     32'(m_tdata[OUT_W-1:89]));
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("priority_thread_scheduler test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    errors       = 0;
    quiet_cycles = 0;
    run_slot     = '0;
    n_live       = 0;
    next_id      = '0;
    now_ticks    = '0;
    n_events     = 0;
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      alive[i] = 1'b0; asleep[i] = 1'b0; blocked[i] = 1'b0;
      prio_tab[i] = '0; wake_tab[i] = '0; ident_tab[i] = '0; nxt[i] = '0; prv[i] = '0;
    end
    for (int e = 0; e < EVENT_SLOTS; e++) begin
      ev_period[e] = '0; ev_due[e] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(250, 0, 0);
    test_random(250, 49, 0);
    test_random(250, 0, 49);
    test_random(250, 16, 16);
    s_tvalid <= 1'b0;

    while (expected_resp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_resp_q.size() == 0) begin
      $display("priority_thread_scheduler test passed");
    end else begin
      $display("priority_thread_scheduler test failed");
    end
    $finish;
  end
endmodule
